### rtl/led_strip_effect_generator_macros.svh
// ----------------------------------------------------------------------------
// LED strip effect generator assertion macros
// Property wrappers for the block's concurrent checks; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_EFFECT_GENERATOR_MACROS_SVH
`define LED_STRIP_EFFECT_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define LSEG_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lseg: same-cycle check failed");
`define LSEG_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lseg: next-cycle check failed");
`else
`define LSEG_ASSERT_IMPLY(name, ante, cons)
`define LSEG_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### rtl/lseg_pkg.sv
// ----------------------------------------------------------------------------
// LED strip effect generator package
// Shared widths, types, register indexes and effect constants.
// ----------------------------------------------------------------------------
package lseg_pkg;

    localparam int STRIP_PIXELS = 512;
    localparam int PIXEL_W      = 9;
    localparam int STEP_W       = 10;
    localparam int PIX_W        = $clog2(STRIP_PIXELS + 1);
    localparam int DIV_W        = PIX_W + 8;
    localparam int CNT_W        = $clog2(DIV_W + 1);
    localparam int CMP_W        = ((PIX_W > STEP_W) ? PIX_W : STEP_W) + 1;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [DIV_W-1:0]   div_num_t;
    typedef logic [CNT_W-1:0]   div_cnt_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [15:0]        aux_t;
    typedef logic [23:0]        colour_t;
    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [2:0]         reg_idx_t;

    localparam reg_idx_t REG_EFFECT     = 3'd0;
    localparam reg_idx_t REG_SPEED      = 3'd1;
    localparam reg_idx_t REG_SIZE       = 3'd2;
    localparam reg_idx_t REG_SPLIT      = 3'd3;
    localparam reg_idx_t REG_POSITION   = 3'd4;
    localparam reg_idx_t REG_INTENSITY  = 3'd5;
    localparam reg_idx_t REG_COLOUR_ONE = 3'd6;
    localparam reg_idx_t REG_COLOUR_TWO = 3'd7;

    localparam logic [1:0] EFF_STATIC  = 2'd0;
    localparam logic [1:0] EFF_RAINBOW = 2'd1;
    localparam logic [1:0] EFF_CHASE   = 2'd2;

    localparam logic [7:0] SPEED_LOW    = 8'd20;
    localparam logic [7:0] SPEED_HIGH   = 8'd235;
    localparam logic [7:0] SPEED_FWD    = 8'd131;
    localparam logic [7:0] SPEED_BACK   = 8'd123;

    localparam int RAINBOW_STEPS = 255;
    localparam int SCALE_DEN     = 255;
    localparam int CHASE_MIN     = 3;
    localparam int CHASE_MAX     = 50;
    localparam int CHASE_SPAN    = CHASE_MAX - CHASE_MIN;
    localparam int DV_MAX        = 8;
    localparam int DV_MIN        = 2;

    localparam logic [7:0] WHEEL_THIRD      = 8'd85;
    localparam logic [7:0] WHEEL_TWO_THIRDS = 8'd170;

    typedef struct packed {
        logic [1:0] effect;
        logic [7:0] speed;
        logic [7:0] size;
        logic [7:0] split;
        logic [7:0] position;
        logic [7:0] intensity;
        colour_t    colour_one;
        colour_t    colour_two;
        step_t      step;
    } cfg_t;

endpackage

### rtl/lseg_div.sv
// ----------------------------------------------------------------------------
// LED strip effect generator serial divider
// Restoring divider, one quotient bit per cycle, shared by all effects.
// ----------------------------------------------------------------------------
module lseg_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lseg_pkg::div_num_t num,
    input  lseg_pkg::pix_t     den,
    output logic               done,
    output lseg_pkg::div_num_t quo,
    output lseg_pkg::pix_t     rem
);

    lseg_pkg::div_cnt_t cnt_reg, cnt_next;
    logic               done_reg, done_next;
    lseg_pkg::div_num_t quo_reg, quo_next;
    lseg_pkg::pix_t     rem_reg, rem_next;
    lseg_pkg::pix_t     den_reg, den_next;

    logic [lseg_pkg::PIX_W:0] trial;
    logic [lseg_pkg::PIX_W:0] diff;
    logic                     fits;

    assign trial = {rem_reg, quo_reg[lseg_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = lseg_pkg::div_cnt_t'(lseg_pkg::DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next numerator bit, subtract where it fits
            rem_next  = fits ? diff[lseg_pkg::PIX_W-1:0] : trial[lseg_pkg::PIX_W-1:0];
            quo_next  = {quo_reg[lseg_pkg::DIV_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == lseg_pkg::div_cnt_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

### rtl/lseg_cfg.sv
// ----------------------------------------------------------------------------
// LED strip effect generator configuration and step index
// Register file for the effect settings plus the frame step counter.
// ----------------------------------------------------------------------------
module lseg_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  lseg_pkg::reg_idx_t index,
    input  logic [23:0]        data,
    input  logic               adv,
    output lseg_pkg::cfg_t     cfg
);

    lseg_pkg::cfg_t cfg_reg, cfg_next;
    lseg_pkg::cmp_t count;
    lseg_pkg::cmp_t inc;
    lseg_pkg::step_t step_adv;

    assign count = (cfg_reg.effect == lseg_pkg::EFF_RAINBOW) ?
                   lseg_pkg::cmp_t'(lseg_pkg::RAINBOW_STEPS) :
                   lseg_pkg::cmp_t'(lseg_pkg::STRIP_PIXELS);
    assign inc   = lseg_pkg::cmp_t'(cfg_reg.step) + 1'b1;

    always_comb
    begin
        step_adv = cfg_reg.step;
        if (cfg_reg.speed < lseg_pkg::SPEED_LOW || cfg_reg.speed > lseg_pkg::SPEED_HIGH)
        begin
            step_adv = cfg_reg.step;
        end
        else if (cfg_reg.speed > lseg_pkg::SPEED_FWD)
        begin
            step_adv = (inc >= count) ? '0 : lseg_pkg::step_t'(inc);
        end
        else if (cfg_reg.speed < lseg_pkg::SPEED_BACK)
        begin
            // load the last step when wrapping below zero or out of range
            if (cfg_reg.step == '0 || lseg_pkg::cmp_t'(cfg_reg.step) > count)
                step_adv = lseg_pkg::step_t'(count - 1'b1);
            else
                step_adv = cfg_reg.step - 1'b1;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (adv)
            cfg_next.step = step_adv;
        if (wr)
        begin
            case (index)
                lseg_pkg::REG_EFFECT:
                begin
                    if (data[1:0] != cfg_reg.effect)
                        cfg_next.step = '0;
                    cfg_next.effect = data[1:0];
                end
                lseg_pkg::REG_SPEED:
                begin
                    if (data[7:0] < lseg_pkg::SPEED_LOW && data[7:0] != cfg_reg.speed)
                        cfg_next.step = '0;
                    cfg_next.speed = data[7:0];
                end
                lseg_pkg::REG_SIZE:       cfg_next.size       = data[7:0];
                lseg_pkg::REG_SPLIT:      cfg_next.split      = data[7:0];
                lseg_pkg::REG_POSITION:   cfg_next.position   = data[7:0];
                lseg_pkg::REG_INTENSITY:  cfg_next.intensity  = data[7:0];
                lseg_pkg::REG_COLOUR_ONE: cfg_next.colour_one = data;
                lseg_pkg::REG_COLOUR_TWO: cfg_next.colour_two = data;
                default:                  cfg_next = cfg_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### rtl/led_strip_effect_generator.sv
// ----------------------------------------------------------------------------
// LED strip effect generator
// Colours one strip pixel per transfer for the static split, rainbow cycle
// or theater chase effect, scaled by intensity.
// Input channel in_valid/in_stall carries pixel_number and frame_end; the
// output channel out_valid/out_stall returns pixel_colour, pixel_out_number
// and frame_last, one result per input transfer, in order.
// Settings are to be written on cfg_valid/cfg_ready (always ready) while
// idle; the block itself does not enforce this. One item at a time: every
// division runs through a shared bit-serial divider and holds the
// sequencer while it loads, shifts out DIV_W quotient bits and then has
// its result picked up. Static split and theater chase need five divisions
// and the rainbow needs three. The output register lets the next item
// start while a result still waits. A stalled result holds the output
// register and the sequencer waits before finishing the next item. The
// step index moves when a frame_end result enters the output register.
// Reset clears all settings, the step index and the output valid.
// ----------------------------------------------------------------------------
`include "led_strip_effect_generator_macros.svh"

module led_strip_effect_generator
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lseg_pkg::pixel_t     pixel_number,
    input  logic                 frame_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lseg_pkg::colour_t    pixel_colour,
    output lseg_pkg::pixel_t     pixel_out_number,
    output logic                 frame_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  lseg_pkg::reg_idx_t   cfg_index,
    input  logic [23:0]          cfg_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SIZE    = 4'd1;
    localparam logic [3:0] ST_SPLIT   = 4'd2;
    localparam logic [3:0] ST_MID     = 4'd3;
    localparam logic [3:0] ST_DMOD    = 4'd4;
    localparam logic [3:0] ST_KMOD    = 4'd5;
    localparam logic [3:0] ST_RB_K    = 4'd6;
    localparam logic [3:0] ST_RB_W    = 4'd7;
    localparam logic [3:0] ST_CH_DV   = 4'd8;
    localparam logic [3:0] ST_CH_STEP = 4'd9;
    localparam logic [3:0] ST_CH_POS  = 4'd10;
    localparam logic [3:0] ST_CH_MOD  = 4'd11;
    localparam logic [3:0] ST_MUL     = 4'd12;
    localparam logic [3:0] ST_OUT     = 4'd13;

    logic [3:0]          state_reg, state_next;
    logic                wait_reg, wait_next;
    logic                out_valid_reg, out_valid_next;
    lseg_pkg::pixel_t    p_reg, p_next;
    logic                fe_reg, fe_next;
    lseg_pkg::pix_t      s_reg, s_next;
    lseg_pkg::pix_t      s1_reg, s1_next;
    lseg_pkg::aux_t      aux_reg, aux_next;
    logic                neg_reg, neg_next;
    lseg_pkg::colour_t   raw_reg, raw_next;
    logic [15:0]         prod_r_reg, prod_r_next;
    logic [15:0]         prod_g_reg, prod_g_next;
    logic [15:0]         prod_b_reg, prod_b_next;
    lseg_pkg::colour_t   colour_out_reg, colour_out_next;
    lseg_pkg::pixel_t    num_out_reg, num_out_next;
    logic                last_out_reg, last_out_next;

    lseg_pkg::cfg_t      cfg;
    logic                cfg_wr;
    logic                adv;
    logic                div_start;
    lseg_pkg::div_num_t  div_num;
    lseg_pkg::pix_t      div_den;
    logic                div_done;
    lseg_pkg::div_num_t  div_quo;
    lseg_pkg::pix_t      div_rem;

    logic                is_chase;
    logic                is_rainbow;
    lseg_pkg::pix_t      half;
    lseg_pkg::pix_t      mid;
    logic                mid_neg;
    logic [7:0]          wheel_pos;
    logic                out_take;

    function automatic lseg_pkg::colour_t wheel(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] t;
        lseg_pkg::colour_t c;
        w = 8'd255 - pos;
        if (w < lseg_pkg::WHEEL_THIRD)
        begin
            t = 8'(w * 8'd3);
            c = {8'd255 - t, 8'd0, t};
        end
        else if (w < lseg_pkg::WHEEL_TWO_THIRDS)
        begin
            t = 8'((w - lseg_pkg::WHEEL_THIRD) * 8'd3);
            c = {8'd0, t, 8'd255 - t};
        end
        else
        begin
            t = 8'((w - lseg_pkg::WHEEL_TWO_THIRDS) * 8'd3);
            c = {t, 8'd255 - t, 8'd0};
        end
        return c;
    endfunction

    // x / 255 for a product of two bytes
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

    assign cfg_wr = cfg_valid && cfg_ready;

    lseg_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg_wr),
        .index (cfg_index),
        .data  (cfg_data),
        .adv   (adv),
        .cfg   (cfg)
    );

    lseg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign is_chase   = (cfg.effect == lseg_pkg::EFF_CHASE);
    assign is_rainbow = (cfg.effect == lseg_pkg::EFF_RAINBOW);
    assign half       = s_reg >> 1;
    assign mid        = lseg_pkg::pix_t'(aux_reg);
    assign mid_neg    = mid < half;
    assign wheel_pos  = div_quo[7:0] + cfg.step[7:0] + cfg.position;
    assign out_take   = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        wait_next       = wait_reg;
        out_valid_next  = out_take ? 1'b0 : out_valid_reg;
        p_next          = p_reg;
        fe_next         = fe_reg;
        s_next          = s_reg;
        s1_next         = s1_reg;
        aux_next        = aux_reg;
        neg_next        = neg_reg;
        raw_next        = raw_reg;
        prod_r_next     = prod_r_reg;
        prod_g_next     = prod_g_reg;
        prod_b_next     = prod_b_reg;
        colour_out_next = colour_out_reg;
        num_out_next    = num_out_reg;
        last_out_next   = last_out_reg;
        adv             = 1'b0;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = lseg_pkg::pix_t'(lseg_pkg::SCALE_DEN);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p_next     = pixel_number;
                    fe_next    = frame_end;
                    wait_next  = 1'b0;
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                div_num = is_chase ?
                    lseg_pkg::div_num_t'(cfg.size) *
                        lseg_pkg::div_num_t'(lseg_pkg::CHASE_SPAN) :
                    lseg_pkg::div_num_t'(cfg.size) *
                        lseg_pkg::div_num_t'(lseg_pkg::STRIP_PIXELS - 2);
                if (wait_reg && div_done)
                begin
                    s_next = lseg_pkg::pix_t'(div_quo) + (is_chase ?
                             lseg_pkg::pix_t'(lseg_pkg::CHASE_MIN) : lseg_pkg::pix_t'(2));
                    state_next = is_chase ? ST_CH_DV : (is_rainbow ? ST_RB_K : ST_SPLIT);
                end
            end
            ST_SPLIT:
            begin
                div_num = lseg_pkg::div_num_t'(cfg.split) * lseg_pkg::div_num_t'(s_reg);
                if (wait_reg && div_done)
                begin
                    s1_next    = lseg_pkg::pix_t'(div_quo);
                    state_next = ST_MID;
                end
            end
            ST_MID:
            begin
                div_num = lseg_pkg::div_num_t'(cfg.position) *
                          lseg_pkg::div_num_t'(lseg_pkg::STRIP_PIXELS);
                if (wait_reg && div_done)
                begin
                    aux_next   = lseg_pkg::aux_t'(div_quo);
                    state_next = ST_DMOD;
                end
            end
            ST_DMOD:
            begin
                // divide the magnitude of mid - size/2, keep the sign aside
                div_num = lseg_pkg::div_num_t'(mid_neg ? half - mid : mid - half);
                div_den = s_reg;
                if (!wait_reg)
                    neg_next = mid_neg;
                if (wait_reg && div_done)
                begin
                    aux_next = neg_reg ?
                        lseg_pkg::aux_t'(s_reg) + lseg_pkg::aux_t'(div_rem) +
                            lseg_pkg::aux_t'(cfg.step) :
                        lseg_pkg::aux_t'(s_reg) - lseg_pkg::aux_t'(div_rem) +
                            lseg_pkg::aux_t'(cfg.step);
                    state_next = ST_KMOD;
                end
            end
            ST_KMOD:
            begin
                div_num = lseg_pkg::div_num_t'(p_reg) + lseg_pkg::div_num_t'(aux_reg);
                div_den = s_reg;
                if (wait_reg && div_done)
                begin
                    raw_next   = (div_rem < s1_reg) ? cfg.colour_one : cfg.colour_two;
                    state_next = ST_MUL;
                end
            end
            ST_RB_K:
            begin
                div_num = lseg_pkg::div_num_t'(p_reg);
                div_den = s_reg;
                if (wait_reg && div_done)
                begin
                    aux_next   = lseg_pkg::aux_t'(div_rem);
                    state_next = ST_RB_W;
                end
            end
            ST_RB_W:
            begin
                div_num = lseg_pkg::div_num_t'(aux_reg) << 8;
                div_den = s_reg;
                if (wait_reg && div_done)
                begin
                    raw_next   = wheel(wheel_pos);
                    state_next = ST_MUL;
                end
            end
            ST_CH_DV:
            begin
                div_num = (lseg_pkg::div_num_t'(s_reg) -
                           lseg_pkg::div_num_t'(lseg_pkg::CHASE_MIN)) *
                          lseg_pkg::div_num_t'(lseg_pkg::DV_MAX - lseg_pkg::DV_MIN);
                div_den = lseg_pkg::pix_t'(lseg_pkg::CHASE_SPAN);
                if (wait_reg && div_done)
                begin
                    s1_next    = lseg_pkg::pix_t'(lseg_pkg::DV_MAX) -
                                 lseg_pkg::pix_t'(div_quo);
                    state_next = ST_CH_STEP;
                end
            end
            ST_CH_STEP:
            begin
                div_num = lseg_pkg::div_num_t'(cfg.step);
                div_den = s1_reg;
                if (wait_reg && div_done)
                begin
                    aux_next   = lseg_pkg::aux_t'(div_quo);
                    state_next = ST_CH_POS;
                end
            end
            ST_CH_POS:
            begin
                div_num = lseg_pkg::div_num_t'(cfg.position) * lseg_pkg::div_num_t'(s_reg);
                if (wait_reg && div_done)
                begin
                    aux_next = {8'd0, 8'(aux_reg + lseg_pkg::aux_t'(s_reg) -
                                         lseg_pkg::aux_t'(div_quo))};
                    state_next = ST_CH_MOD;
                end
            end
            ST_CH_MOD:
            begin
                div_num = lseg_pkg::div_num_t'(p_reg) + lseg_pkg::div_num_t'(aux_reg);
                div_den = s_reg;
                if (wait_reg && div_done)
                begin
                    raw_next   = (div_rem == '0) ? cfg.colour_one : cfg.colour_two;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_r_next = raw_reg[23:16] * cfg.intensity;
                prod_g_next = raw_reg[15:8] * cfg.intensity;
                prod_b_next = raw_reg[7:0] * cfg.intensity;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    colour_out_next = {div255(prod_r_reg), div255(prod_g_reg),
                                       div255(prod_b_reg)};
                    num_out_next    = p_reg;
                    last_out_next   = fe_reg;
                    out_valid_next  = 1'b1;
                    adv             = fe_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // launch the divider once on entry to any dividing state
        if (state_reg != ST_IDLE && state_reg != ST_MUL && state_reg != ST_OUT)
        begin
            if (!wait_reg)
            begin
                div_start = 1'b1;
                wait_next = 1'b1;
            end
            else if (div_done)
            begin
                wait_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        fe_reg         <= fe_next;
        s_reg          <= s_next;
        s1_reg         <= s1_next;
        aux_reg        <= aux_next;
        neg_reg        <= neg_next;
        raw_reg        <= raw_next;
        prod_r_reg     <= prod_r_next;
        prod_g_reg     <= prod_g_next;
        prod_b_reg     <= prod_b_next;
        colour_out_reg <= colour_out_next;
        num_out_reg    <= num_out_next;
        last_out_reg   <= last_out_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign pixel_colour     = colour_out_reg;
    assign pixel_out_number = num_out_reg;
    assign frame_last       = last_out_reg;

    `LSEG_ASSERT_IMPLY(a_done_while_waiting, div_done, wait_reg)
    `LSEG_ASSERT_NEXT(a_step_holds, !cfg_wr && !adv, $stable(cfg.step))
    `LSEG_ASSERT_NEXT(a_out_waits, state_reg == ST_OUT && out_valid_reg && out_stall, state_reg == ST_OUT)

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED strip effect generator testbench
// Drives pixel transfers through all three effects and several register
// settings, predicts each pixel colour and the step index, and compares
// every returned pixel with its prediction, under varied idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        lseg_pkg::pixel_t pix;
        logic             fe;
    } pixel_req_t;

    typedef struct packed {
        lseg_pkg::colour_t colour;
        lseg_pkg::pixel_t  pix;
        logic              fe;
    } pixel_res_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    lseg_pkg::pixel_t   pixel_number;
    logic               frame_end;
    logic               out_valid;
    logic               out_stall;
    lseg_pkg::colour_t  pixel_colour;
    lseg_pkg::pixel_t   pixel_out_number;
    logic               frame_last;
    logic               cfg_valid;
    logic               cfg_ready;
    lseg_pkg::reg_idx_t cfg_index;
    logic [23:0]        cfg_data;

    // predictor state
    logic [1:0]        m_effect;
    logic [7:0]        m_speed, m_size, m_split, m_position, m_intensity;
    lseg_pkg::colour_t m_colour_one, m_colour_two;
    lseg_pkg::step_t   m_step;

    pixel_req_t pending_pixels[$];
    pixel_res_t expected_pixels[$];
    int         idle_pct;
    int         stall_pct;
    int         hold_off;
    int         errors;
    int         quiet_cycles;
    bit         stim_done;

    led_strip_effect_generator dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic lseg_pkg::colour_t scale_colour(lseg_pkg::colour_t c);
        logic [15:0] r, g, b;
        r = c[23:16] * m_intensity / 255;
        g = c[15:8] * m_intensity / 255;
        b = c[7:0] * m_intensity / 255;
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function automatic lseg_pkg::colour_t wheel_colour(int unsigned w);
        int unsigned v;
        v = 255 - (w & 8'hFF);
        if (v < 85)
            return {8'(255 - v * 3), 8'd0, 8'(v * 3)};
        if (v < 170)
        begin
            v = v - 85;
            return {8'd0, 8'(v * 3), 8'(255 - v * 3)};
        end
        v = v - 170;
        return {8'(v * 3), 8'(255 - v * 3), 8'd0};
    endfunction

    function automatic lseg_pkg::colour_t predict_colour(int unsigned p);
        int unsigned s, s1, off, k, m, dv, a;
        int mid, d, q;
        s = m_size * (lseg_pkg::STRIP_PIXELS - 2) / 255 + 2;
        if (m_effect == lseg_pkg::EFF_RAINBOW)
        begin
            k = p % s;
            return scale_colour(wheel_colour(k * 256 / s + m_step + m_position));
        end
        if (m_effect == lseg_pkg::EFF_CHASE)
        begin
            m = m_size * 47 / 255 + 3;
            dv = 8 - ((m - 3) * 6) / 47;
            a = (m_step / dv + (m - m_position * m / 255)) & 8'hFF;
            return scale_colour(((p + a) % m) == 0 ? m_colour_one : m_colour_two);
        end
        s1 = m_split * s / 255;
        mid = int'(m_position * lseg_pkg::STRIP_PIXELS / 255);
        d = mid - int'(s / 2);
        q = d / int'(s);
        off = (s - unsigned'(d) + unsigned'(q) * s + m_step) & 16'hFFFF;
        k = (p + off) % s;
        return scale_colour(k < s1 ? m_colour_one : m_colour_two);
    endfunction

    function automatic void advance_step();
        int unsigned t, st;
        t = (m_effect == lseg_pkg::EFF_RAINBOW) ? lseg_pkg::RAINBOW_STEPS
                                                 : lseg_pkg::STRIP_PIXELS;
        st = m_step;
        if (m_speed < lseg_pkg::SPEED_LOW || m_speed > lseg_pkg::SPEED_HIGH)
            return;
        if (m_speed > lseg_pkg::SPEED_FWD)
        begin
            st = st + 1;
            if (st >= t)
                st = 0;
        end
        else if (m_speed < lseg_pkg::SPEED_BACK)
        begin
            if (st == 0 || st > t)
                st = t - 1;
            else
                st = st - 1;
        end
        m_step = st[lseg_pkg::STEP_W-1:0];
    endfunction

    task automatic write_reg(lseg_pkg::reg_idx_t idx, logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lseg_pkg::REG_EFFECT:
            begin
                if (val[1:0] != m_effect)
                    m_step = '0;
                m_effect = val[1:0];
            end
            lseg_pkg::REG_SPEED:
            begin
                if (val[7:0] < lseg_pkg::SPEED_LOW && val[7:0] != m_speed)
                    m_step = '0;
                m_speed = val[7:0];
            end
            lseg_pkg::REG_SIZE:       m_size = val[7:0];
            lseg_pkg::REG_SPLIT:      m_split = val[7:0];
            lseg_pkg::REG_POSITION:   m_position = val[7:0];
            lseg_pkg::REG_INTENSITY:  m_intensity = val[7:0];
            lseg_pkg::REG_COLOUR_ONE: m_colour_one = val;
            lseg_pkg::REG_COLOUR_TWO: m_colour_two = val;
            default: ;
        endcase
    endtask

    // check away from the active edge so queue updates have settled
    task automatic drain();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0);
        repeat (120) @(posedge clk);
    endtask

    task automatic random_regs(logic [1:0] eff);
        logic [7:0] sp;
        case ($urandom_range(0, 3))
            0: sp = 8'($urandom_range(0, 19));
            1: sp = 8'($urandom_range(20, 122));
            2: sp = 8'($urandom_range(132, 235));
            default: sp = 8'($urandom_range(0, 255));
        endcase
        write_reg(lseg_pkg::REG_EFFECT, 24'(eff));
        write_reg(lseg_pkg::REG_SPEED, 24'(sp));
        write_reg(lseg_pkg::REG_SIZE, $urandom_range(0, 3) == 0 ?
                  24'($urandom_range(0, 255)) : 24'($urandom_range(0, 40)));
        write_reg(lseg_pkg::REG_SPLIT, 24'($urandom_range(0, 255)));
        write_reg(lseg_pkg::REG_POSITION, 24'($urandom_range(0, 255)));
        write_reg(lseg_pkg::REG_INTENSITY, $urandom_range(0, 1) ?
                  24'd255 : 24'($urandom_range(0, 255)));
        write_reg(lseg_pkg::REG_COLOUR_ONE, 24'($urandom));
        write_reg(lseg_pkg::REG_COLOUR_TWO, 24'($urandom));
    endtask

    // a frame of consecutive pixels closed by a frame end
    task automatic queue_frame(int len);
        int start;
        start = $urandom_range(0, 511);
        for (int i = 0; i < len; i++)
            pending_pixels.push_back('{pix: lseg_pkg::pixel_t'(start + i),
                                       fe: (i == len - 1)});
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_number = '0;
        frame_end = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lseg_pkg::REG_EFFECT;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        errors = 0;
        stim_done = 0;
        m_effect = lseg_pkg::EFF_STATIC; m_speed = 0; m_size = 0; m_split = 0;
        m_position = 0; m_intensity = 0; m_colour_one = 0; m_colour_two = 0;
        m_step = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes with registers at reset, then all effects
        pending_pixels.push_back('{pix: 9'd0, fe: 1'b0});
        pending_pixels.push_back('{pix: 9'd511, fe: 1'b1});
        drain();
        write_reg(lseg_pkg::REG_INTENSITY, 24'd255);
        write_reg(lseg_pkg::REG_COLOUR_ONE, 24'hFFFFFF);
        write_reg(lseg_pkg::REG_COLOUR_TWO, 24'h123456);
        write_reg(lseg_pkg::REG_SPEED, 24'd255);
        write_reg(lseg_pkg::REG_SIZE, 24'd255);
        write_reg(lseg_pkg::REG_SPLIT, 24'd128);
        write_reg(lseg_pkg::REG_POSITION, 24'd255);
        for (int e = 0; e < 4; e++)
        begin
            write_reg(lseg_pkg::REG_EFFECT, 24'(e));
            pending_pixels.push_back('{pix: 9'd0, fe: 1'b1});
            pending_pixels.push_back('{pix: 9'd511, fe: 1'b1});
            pending_pixels.push_back('{pix: 9'h155, fe: 1'b0});
            pending_pixels.push_back('{pix: 9'h0AA, fe: 1'b1});
            drain();
        end
        // step back from zero, then forward across the wrap
        write_reg(lseg_pkg::REG_EFFECT, 24'(lseg_pkg::EFF_RAINBOW));
        write_reg(lseg_pkg::REG_SPEED, 24'd20);
        pending_pixels.push_back('{pix: 9'd7, fe: 1'b1});
        pending_pixels.push_back('{pix: 9'd8, fe: 1'b1});
        drain();
        write_reg(lseg_pkg::REG_SPEED, 24'd235);
        pending_pixels.push_back('{pix: 9'd9, fe: 1'b1});
        pending_pixels.push_back('{pix: 9'd10, fe: 1'b1});
        drain();
        // step back from zero over the strip count, then hold
        write_reg(lseg_pkg::REG_EFFECT, 24'(lseg_pkg::EFF_CHASE));
        write_reg(lseg_pkg::REG_SPEED, 24'd131);
        write_reg(lseg_pkg::REG_SPEED, 24'd122);
        pending_pixels.push_back('{pix: 9'd1, fe: 1'b1});
        drain();
        write_reg(lseg_pkg::REG_SPEED, 24'd123);
        write_reg(lseg_pkg::REG_SIZE, 24'd0);
        write_reg(lseg_pkg::REG_POSITION, 24'd0);
        write_reg(lseg_pkg::REG_INTENSITY, 24'd0);
        pending_pixels.push_back('{pix: 9'd2, fe: 1'b1});
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            random_regs(2'($urandom_range(0, 3)));
            if (ph == 4)
                hold_off = 300;
            for (int n = 0; n < 50; )
            begin
                int len;
                if ($urandom_range(0, 9) < 8)
                    len = $urandom_range(1, 8);
                else
                begin
                    len = 1;
                    pending_pixels.push_back('{pix: lseg_pkg::pixel_t'($urandom),
                                               fe: 1'($urandom)});
                    n = n + len;
                    continue;
                end
                queue_frame(len);
                n = n + len;
            end
            drain();
        end
        stim_done = 1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid && !in_stall)
                void'(pending_pixels.pop_front());
            if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid     <= 1'b1;
                pixel_number <= pending_pixels[0].pix;
                frame_end    <= pending_pixels[0].fe;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // prediction on accepted input
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_pixels.push_back('{colour: predict_colour(pixel_number),
                                        pix: pixel_number, fe: frame_end});
            if (frame_end)
                advance_step();
        end
    end

    // monitor with receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel %h/%0d/%0d", $time, pixel_colour,
                             pixel_out_number, frame_last);
                    errors = errors + 1;
                end
                else
                begin
                    pixel_res_t e;
                    e = expected_pixels.pop_front();
                    if (e.colour !== pixel_colour)
                    begin
                        $display("%0t: colour exp %h got %h", $time, e.colour, pixel_colour);
                        errors = errors + 1;
                    end
                    if (e.pix !== pixel_out_number)
                    begin
                        $display("%0t: pixel exp %0d got %0d", $time, e.pix,
                                 pixel_out_number);
                        errors = errors + 1;
                    end
                    if (e.fe !== frame_last)
                    begin
                        $display("%0t: frame_last exp %0d got %0d", $time, e.fe,
                                 frame_last);
                        errors = errors + 1;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog and end of run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else if (stim_done)
        begin
            if (errors == 0 && expected_pixels.size() == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
            $finish;
        end
    end

    initial quiet_cycles = 0;
endmodule

### filelist.f
+incdir+rtl
rtl/lseg_pkg.sv
rtl/lseg_div.sv
rtl/lseg_cfg.sv
rtl/led_strip_effect_generator.sv
tb/tb.sv
